FILE: hw/rtl/mwk_pkg.sv
// ============================================================================
// mwk_pkg
// Shared widths, pipeline depths, configuration layout and constant tables
// for the mecanum wheel speed kinematics unit.
// ============================================================================
package mwk_pkg;

    localparam int ANGLE_W  = 16;
    localparam int VEL_W    = 24;
    localparam int CFG_W    = 16;
    localparam int SPEED_W  = 32;
    localparam int SUM_W    = 45;
    localparam int RAD_W    = 52;
    localparam int NUM_W    = 52;
    localparam int CORDIC_N = 30;
    localparam int CORDIC_W = 34;
    localparam int SQRT_N   = 32;
    localparam int SQ_W     = 64;
    localparam int SDIV_N   = 32;

    // Stage counts of the three datapath parts.
    localparam int FLAT  = 3;
    localparam int RLAT  = 1 + CORDIC_N + 4 + SQRT_N + 1 + NUM_W + 1;
    localparam int SLAT  = 1 + SDIV_N + 1;
    localparam int TOTAL = RLAT + SLAT + 1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_COS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_SIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVER_SUM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRCLE_RAD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ELLIPSE_MAJ  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ELLIPSE_MIN  = 3'd7;

    localparam logic [CFG_W-1:0] RST_YAW_COS   = 16'd16384;
    localparam logic [CFG_W-1:0] RST_LEVER_SUM = 16'd4096;
    localparam logic [CFG_W-1:0] RST_RADIUS    = 16'd409;

    // CORDIC gain compensation, Q4.30.
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;

    typedef struct packed {
        logic signed [CFG_W-1:0] offset_x;
        logic signed [CFG_W-1:0] offset_y;
        logic signed [CFG_W-1:0] yaw_cos;
        logic signed [CFG_W-1:0] yaw_sin;
        logic [CFG_W-1:0]        lever_sum;
        logic [CFG_W-1:0]        circle_radius;
        logic [CFG_W-1:0]        ellipse_major;
        logic [CFG_W-1:0]        ellipse_minor;
    } cfg_t;

    // Arctangent of 2^-i on a 2^32-per-turn scale.
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/mwk_if.sv
// ============================================================================
// mwk_if
// Valid/ready channels carrying velocity commands and wheel speed results.
// ============================================================================
interface mwk_cmd_if;
    logic                                valid;
    logic                                ready;
    logic signed [mwk_pkg::VEL_W-1:0]    ref_vx;
    logic signed [mwk_pkg::VEL_W-1:0]    ref_vy;
    logic signed [mwk_pkg::VEL_W-1:0]    ref_wz;
    logic                                ref_valid;
    logic [mwk_pkg::ANGLE_W-1:0]         angle_front_left;
    logic [mwk_pkg::ANGLE_W-1:0]         angle_front_right;
    logic [mwk_pkg::ANGLE_W-1:0]         angle_rear_right;
    logic [mwk_pkg::ANGLE_W-1:0]         angle_rear_left;

    modport source (
        output valid, ref_vx, ref_vy, ref_wz, ref_valid,
        output angle_front_left, angle_front_right, angle_rear_right, angle_rear_left,
        input  ready
    );
    modport sink (
        input  valid, ref_vx, ref_vy, ref_wz, ref_valid,
        input  angle_front_left, angle_front_right, angle_rear_right, angle_rear_left,
        output ready
    );
endinterface

interface mwk_speed_if;
    logic                                valid;
    logic                                ready;
    logic signed [mwk_pkg::SPEED_W-1:0]  speed_front_left;
    logic signed [mwk_pkg::SPEED_W-1:0]  speed_front_right;
    logic signed [mwk_pkg::SPEED_W-1:0]  speed_rear_right;
    logic signed [mwk_pkg::SPEED_W-1:0]  speed_rear_left;
    logic                                clipped;

    modport source (
        output valid, speed_front_left, speed_front_right, speed_rear_right,
        output speed_rear_left, clipped,
        input  ready
    );
    modport sink (
        input  valid, speed_front_left, speed_front_right, speed_rear_right,
        input  speed_rear_left, clipped,
        output ready
    );
endinterface

FILE: hw/rtl/mwk_front.sv
// ============================================================================
// mwk_front
// Three-stage body-to-wheel mixing: frame rotation, lever terms, wheel sums.
// ============================================================================
module mwk_front (
    input  logic                             clk,
    input  logic                             en,
    input  mwk_pkg::cfg_t                    cfg,
    input  logic signed [mwk_pkg::VEL_W-1:0] vx,
    input  logic signed [mwk_pkg::VEL_W-1:0] vy,
    input  logic signed [mwk_pkg::VEL_W-1:0] wz,
    output logic signed [mwk_pkg::SUM_W-1:0] sum_fl,
    output logic signed [mwk_pkg::SUM_W-1:0] sum_fr,
    output logic signed [mwk_pkg::SUM_W-1:0] sum_rr,
    output logic signed [mwk_pkg::SUM_W-1:0] sum_rl
);

    localparam int PW = 40;
    localparam int LW = 41;
    localparam int MW = 43;
    localparam int SW = mwk_pkg::SUM_W;

    logic signed [PW-1:0] cvx_reg, svy_reg, svx_reg, cvy_reg, oywz_reg, oxwz_reg;
    logic signed [LW-1:0] lwz_reg;
    logic signed [MW-1:0] vxc_reg, vyc_reg, lw_reg;
    logic signed [SW-1:0] fl_reg, fr_reg, rr_reg, rl_reg;
    logic signed [MW-1:0] vxc_next, vyc_next, lw_next;

    always_comb
    begin
        vxc_next = MW'(cvx_reg) - MW'(svy_reg) + (MW'(oywz_reg) <<< 2);
        vyc_next = MW'(svx_reg) + MW'(cvy_reg) - (MW'(oxwz_reg) <<< 2);
        lw_next  = MW'(lwz_reg) <<< 2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cvx_reg  <= PW'(cfg.yaw_cos) * PW'(vx);
            svy_reg  <= PW'(cfg.yaw_sin) * PW'(vy);
            svx_reg  <= PW'(cfg.yaw_sin) * PW'(vx);
            cvy_reg  <= PW'(cfg.yaw_cos) * PW'(vy);
            oywz_reg <= PW'(cfg.offset_y) * PW'(wz);
            oxwz_reg <= PW'(cfg.offset_x) * PW'(wz);
            lwz_reg  <= LW'($signed({1'b0, cfg.lever_sum})) * LW'(wz);
            vxc_reg  <= vxc_next;
            vyc_reg  <= vyc_next;
            lw_reg   <= lw_next;
            fl_reg   <= SW'(vxc_reg) - SW'(vyc_reg) - SW'(lw_reg);
            fr_reg   <= SW'(vxc_reg) + SW'(vyc_reg) + SW'(lw_reg);
            rr_reg   <= SW'(vxc_reg) - SW'(vyc_reg) + SW'(lw_reg);
            rl_reg   <= SW'(vxc_reg) + SW'(vyc_reg) - SW'(lw_reg);
        end
    end

    assign sum_fl = fl_reg;
    assign sum_fr = fr_reg;
    assign sum_rr = rr_reg;
    assign sum_rl = rl_reg;

endmodule

FILE: hw/rtl/mwk_radius.sv
// ============================================================================
// mwk_radius
// Pipelined effective wheel radius: CORDIC sine/cosine, ellipse norm by a
// digit-per-stage square root, and a bit-per-stage restoring divider.
// ============================================================================
module mwk_radius (
    input  logic                             clk,
    input  logic                             en,
    input  mwk_pkg::cfg_t                    cfg,
    input  logic [mwk_pkg::ANGLE_W-1:0]      angle,
    output logic [mwk_pkg::RAD_W-1:0]        radius
);

    localparam int AW  = mwk_pkg::ANGLE_W;
    localparam int CW  = mwk_pkg::CORDIC_W;
    localparam int CN  = mwk_pkg::CORDIC_N;
    localparam int QW  = mwk_pkg::SQ_W;
    localparam int SN  = mwk_pkg::SQRT_N;
    localparam int NW  = mwk_pkg::NUM_W;
    localparam int RW  = mwk_pkg::RAD_W;
    localparam int CL  = mwk_pkg::RLAT - 1;
    localparam int NUM_SHIFT = 19;
    localparam logic [AW-1:0] HALF    = {1'b1, {(AW-1){1'b0}}};
    localparam logic [AW-1:0] QUARTER = {2'b01, {(AW-2){1'b0}}};
    localparam logic signed [CW-1:0] ONE_Q30 = $signed({{(CW-31){1'b0}}, 1'b1, 30'd0});

    function automatic logic [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] c;
        if (v < 0)
            c = '0;
        else if (v > ONE_Q30)
            c = ONE_Q30;
        else
            c = v;
        return 16'((c + CW'(16384)) >>> 15);
    endfunction

    logic [AW-1:0]        p_next;
    logic signed [CW-1:0] z0_reg;
    logic [CL-1:0]        circ_line_reg;

    logic signed [CW-1:0] cx_reg [CN];
    logic signed [CW-1:0] cy_reg [CN];
    logic signed [CW-1:0] cz_reg [CN];

    logic [15:0]   cq_reg, sq_reg;
    logic [31:0]   bc_reg, as_reg;
    logic [QW-1:0] bc2_reg, as2_reg, norm2_reg;

    logic [QW-1:0] sv_reg [SN];
    logic [QW-1:0] sr_reg [SN];

    logic [31:0]   nn_reg;
    logic [NW-1:0] num_reg;
    logic [31:0]   ab_next;

    logic [31:0]   rem_reg [NW];
    logic [NW-1:0] q_reg   [NW];
    logic [NW-1:0] dnum_reg [NW];
    logic [31:0]   dn_reg  [NW];

    logic [RW-1:0] radius_reg;
    logic          zero_next;

    // Fold the ellipse-half angle into the first quarter turn.
    always_comb
    begin
        p_next = angle - HALF;
        if (p_next > QUARTER)
            p_next = HALF - p_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg        <= $signed({{(CW-32){1'b0}}, p_next, {(32-AW){1'b0}}});
            circ_line_reg <= {circ_line_reg[CL-2:0], ~angle[AW-1]};
        end
    end

    for (genvar i = 0; i < CN; i++)
    begin : g_cordic
        logic signed [CW-1:0] xi, yi, zi, ai;
        if (i == 0)
        begin : g_first
            assign xi = mwk_pkg::CORDIC_X0;
            assign yi = '0;
            assign zi = z0_reg;
        end
        else
        begin : g_rest
            assign xi = cx_reg[i-1];
            assign yi = cy_reg[i-1];
            assign zi = cz_reg[i-1];
        end
        assign ai = $signed({{(CW-32){1'b0}}, mwk_pkg::atan_turn(i)});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zi >= 0)
                begin
                    cx_reg[i] <= xi - (yi >>> i);
                    cy_reg[i] <= yi + (xi >>> i);
                    cz_reg[i] <= zi - ai;
                end
                else
                begin
                    cx_reg[i] <= xi + (yi >>> i);
                    cy_reg[i] <= yi - (xi >>> i);
                    cz_reg[i] <= zi + ai;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cq_reg    <= to_q15(cx_reg[CN-1]);
            sq_reg    <= to_q15(cy_reg[CN-1]);
            bc_reg    <= 32'(cfg.ellipse_minor) * 32'(cq_reg);
            as_reg    <= 32'(cfg.ellipse_major) * 32'(sq_reg);
            bc2_reg   <= QW'(bc_reg) * QW'(bc_reg);
            as2_reg   <= QW'(as_reg) * QW'(as_reg);
            norm2_reg <= bc2_reg + as2_reg;
        end
    end

    for (genvar k = 0; k < SN; k++)
    begin : g_sqrt
        localparam logic [QW-1:0] BIT = QW'(1) << (62 - 2 * k);
        logic [QW-1:0] vi, ri;
        if (k == 0)
        begin : g_first
            assign vi = norm2_reg;
            assign ri = '0;
        end
        else
        begin : g_rest
            assign vi = sv_reg[k-1];
            assign ri = sr_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (vi >= ri + BIT)
                begin
                    sv_reg[k] <= vi - (ri + BIT);
                    sr_reg[k] <= (ri >> 1) + BIT;
                end
                else
                begin
                    sv_reg[k] <= vi;
                    sr_reg[k] <= ri >> 1;
                end
            end
        end
    end

    assign ab_next = 32'(cfg.ellipse_major) * 32'(cfg.ellipse_minor);

    // Dividend a*b*2^19 plus half the divisor, so the quotient rounds half up.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nn_reg  <= sr_reg[SN-1][31:0];
            num_reg <= NW'({ab_next, {NUM_SHIFT{1'b0}}}) + NW'(sr_reg[SN-1][31:1]);
        end
    end

    for (genvar j = 0; j < NW; j++)
    begin : g_div
        logic [31:0]   rp, dn;
        logic [NW-1:0] qp, np;
        logic [32:0]   t;
        if (j == 0)
        begin : g_first
            assign rp = '0;
            assign qp = '0;
            assign np = num_reg;
            assign dn = nn_reg;
        end
        else
        begin : g_rest
            assign rp = rem_reg[j-1];
            assign qp = q_reg[j-1];
            assign np = dnum_reg[j-1];
            assign dn = dn_reg[j-1];
        end
        assign t = {rp, np[NW-1-j]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dnum_reg[j] <= np;
                dn_reg[j]   <= dn;
                if (t >= {1'b0, dn})
                begin
                    rem_reg[j] <= 32'(t - {1'b0, dn});
                    q_reg[j]   <= {qp[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= t[31:0];
                    q_reg[j]   <= {qp[NW-2:0], 1'b0};
                end
            end
        end
    end

    assign zero_next = (cfg.ellipse_major == '0) || (cfg.ellipse_minor == '0) ||
                       (dn_reg[NW-1] == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (circ_line_reg[CL-1])
                radius_reg <= RW'({cfg.circle_radius, 4'd0});
            else if (zero_next)
                radius_reg <= '0;
            else
                radius_reg <= q_reg[NW-1];
        end
    end

    assign radius = radius_reg;

endmodule

FILE: hw/rtl/mwk_speed.sv
// ============================================================================
// mwk_speed
// Pipelined rounded, saturating division of one wheel sum by its radius.
// ============================================================================
module mwk_speed (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [mwk_pkg::SUM_W-1:0]   sum,
    input  logic [mwk_pkg::RAD_W-1:0]          radius,
    output logic signed [mwk_pkg::SPEED_W-1:0] speed,
    output logic                               clip
);

    localparam int SW = mwk_pkg::SUM_W;
    localparam int RW = mwk_pkg::RAD_W;
    localparam int DN = mwk_pkg::SDIV_N;
    localparam int OW = mwk_pkg::SPEED_W;
    localparam logic [DN-1:0] LIM_POS = {1'b0, {(DN-1){1'b1}}};
    localparam logic [DN-1:0] LIM_NEG = {1'b1, {(DN-1){1'b0}}};

    logic [SW-1:0] mag_next;
    logic [RW-1:0] d_next;

    logic [RW-1:0] d_reg, r_reg;
    logic          neg_reg, magz_reg, ovf_reg;

    logic [RW-1:0] rem_reg [DN];
    logic [DN-1:0] q_reg   [DN];
    logic [RW-1:0] dd_reg  [DN];
    logic [RW-1:0] dr_reg  [DN];
    logic [DN:0]   neg_line_reg, magz_line_reg, ovf_line_reg;

    logic signed [OW-1:0] speed_reg;
    logic                 clip_reg;
    logic [DN-1:0]        lim_next, qsat_next;
    logic                 clip_next;

    always_comb
    begin
        mag_next = sum[SW-1] ? SW'(-sum) : SW'(sum);
        d_next   = RW'({mag_next, 6'd0}) + (radius >> 1);
    end

    // A quotient of 2^32 or more shows as a high dividend part not below r.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= d_next;
            r_reg    <= radius;
            neg_reg  <= sum[SW-1];
            magz_reg <= (mag_next == '0);
            ovf_reg  <= (RW'(d_next[RW-1:DN]) >= radius);
        end
    end

    for (genvar j = 0; j < DN; j++)
    begin : g_div
        logic [RW-1:0] rp, dp, rd;
        logic [DN-1:0] qp;
        logic [RW:0]   t;
        if (j == 0)
        begin : g_first
            assign rp = RW'(d_reg[RW-1:DN]);
            assign qp = '0;
            assign dp = d_reg;
            assign rd = r_reg;
        end
        else
        begin : g_rest
            assign rp = rem_reg[j-1];
            assign qp = q_reg[j-1];
            assign dp = dd_reg[j-1];
            assign rd = dr_reg[j-1];
        end
        assign t = {rp, dp[DN-1-j]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dd_reg[j] <= dp;
                dr_reg[j] <= rd;
                if (t >= {1'b0, rd})
                begin
                    rem_reg[j] <= RW'(t - {1'b0, rd});
                    q_reg[j]   <= {qp[DN-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= t[RW-1:0];
                    q_reg[j]   <= {qp[DN-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_line_reg  <= {neg_line_reg[DN-1:0], neg_reg};
            magz_line_reg <= {magz_line_reg[DN-1:0], magz_reg};
            ovf_line_reg  <= {ovf_line_reg[DN-1:0], ovf_reg};
        end
    end

    always_comb
    begin
        lim_next = neg_line_reg[DN-1] ? LIM_NEG : LIM_POS;
        if (ovf_line_reg[DN-1] || (q_reg[DN-1] > lim_next))
        begin
            qsat_next = lim_next;
            clip_next = 1'b1;
        end
        else
        begin
            qsat_next = q_reg[DN-1];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (magz_line_reg[DN-1])
            begin
                speed_reg <= '0;
                clip_reg  <= 1'b0;
            end
            else
            begin
                speed_reg <= neg_line_reg[DN-1] ? $signed(OW'(-qsat_next)) : $signed(OW'(qsat_next));
                clip_reg  <= clip_next;
            end
        end
    end

    assign speed = speed_reg;
    assign clip  = clip_reg;

endmodule

FILE: hw/rtl/mecanum_wheel_speed_kinematics_unit.sv
// ============================================================================
// mecanum_wheel_speed_kinematics_unit
// Inverse kinematics of a four-wheel mecanum base: body velocity command in,
// four rounded and saturated wheel speed commands out.
// ============================================================================
// Throughput: one beat per cycle; every stage is a register, so a new command
// may enter in each cycle while earlier ones are still in flight.
// The whole pipeline advances together and holds while a result waits.
// Reset clears the valid bits of all stages and loads the configuration
// registers with their default values; no clearing pass is needed.
module mecanum_wheel_speed_kinematics_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mwk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwk_pkg::CFG_W-1:0]          cfg_data,
    mwk_cmd_if.sink                            cmd,
    mwk_speed_if.source                        wheel
);

    localparam int TOT = mwk_pkg::TOTAL;
    localparam int DLY = mwk_pkg::RLAT - mwk_pkg::FLAT;
    localparam int SW  = mwk_pkg::SUM_W;
    localparam int RW  = mwk_pkg::RAD_W;
    localparam int OW  = mwk_pkg::SPEED_W;

    // Configuration registers. The user must write them only while the pipeline is empty,
    // so that every stage can read them directly; the block itself does not enforce this.
    mwk_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x      <= '0;
            cfg_reg.offset_y      <= '0;
            cfg_reg.yaw_cos       <= $signed(mwk_pkg::RST_YAW_COS);
            cfg_reg.yaw_sin       <= '0;
            cfg_reg.lever_sum     <= mwk_pkg::RST_LEVER_SUM;
            cfg_reg.circle_radius <= mwk_pkg::RST_RADIUS;
            cfg_reg.ellipse_major <= mwk_pkg::RST_RADIUS;
            cfg_reg.ellipse_minor <= mwk_pkg::RST_RADIUS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mwk_pkg::CFG_OFFSET_X:    cfg_reg.offset_x      <= $signed(cfg_data);
                mwk_pkg::CFG_OFFSET_Y:    cfg_reg.offset_y      <= $signed(cfg_data);
                mwk_pkg::CFG_YAW_COS:     cfg_reg.yaw_cos       <= $signed(cfg_data);
                mwk_pkg::CFG_YAW_SIN:     cfg_reg.yaw_sin       <= $signed(cfg_data);
                mwk_pkg::CFG_LEVER_SUM:   cfg_reg.lever_sum     <= cfg_data;
                mwk_pkg::CFG_CIRCLE_RAD:  cfg_reg.circle_radius <= cfg_data;
                mwk_pkg::CFG_ELLIPSE_MAJ: cfg_reg.ellipse_major <= cfg_data;
                mwk_pkg::CFG_ELLIPSE_MIN: cfg_reg.ellipse_minor <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Global advance: the pipeline moves whenever the output register is
    // empty or its beat is being taken this cycle.
    logic           adv;
    logic [TOT-1:0] vld_reg;
    logic [TOT-2:0] refv_reg;

    assign adv       = ~vld_reg[TOT-1] | wheel.ready;
    assign cmd.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TOT-2:0], cmd.valid};
    end

    // The reference-valid flag rides along so an invalid command gives zeros.
    always_ff @(posedge clk)
    begin
        if (adv)
            refv_reg <= {refv_reg[TOT-3:0], cmd.ref_valid};
    end

    // Wheel sums, ready after the front stages.
    logic signed [SW-1:0] sums [4];

    mwk_front u_front (
        .clk    (clk),
        .en     (adv),
        .cfg    (cfg_reg),
        .vx     (cmd.ref_vx),
        .vy     (cmd.ref_vy),
        .wz     (cmd.ref_wz),
        .sum_fl (sums[0]),
        .sum_fr (sums[1]),
        .sum_rr (sums[2]),
        .sum_rl (sums[3])
    );

    // Effective radius of each wheel, computed in parallel with the sums.
    logic [mwk_pkg::ANGLE_W-1:0] angles [4];
    logic [RW-1:0]               radii  [4];

    assign angles[0] = cmd.angle_front_left;
    assign angles[1] = cmd.angle_front_right;
    assign angles[2] = cmd.angle_rear_right;
    assign angles[3] = cmd.angle_rear_left;

    // The sums wait in a delay line until the matching radii are out.
    logic signed [SW-1:0] sum_dly_reg [DLY][4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int w = 0; w < 4; w++)
            begin
                sum_dly_reg[0][w] <= sums[w];
                for (int d = 1; d < DLY; d++)
                    sum_dly_reg[d][w] <= sum_dly_reg[d-1][w];
            end
        end
    end

    logic signed [OW-1:0] speeds [4];
    logic [3:0]           clips;

    for (genvar w = 0; w < 4; w++)
    begin : g_wheel
        mwk_radius u_radius (
            .clk    (clk),
            .en     (adv),
            .cfg    (cfg_reg),
            .angle  (angles[w]),
            .radius (radii[w])
        );

        mwk_speed u_speed (
            .clk    (clk),
            .en     (adv),
            .sum    (sum_dly_reg[DLY-1][w]),
            .radius (radii[w]),
            .speed  (speeds[w]),
            .clip   (clips[w])
        );
    end

    // Output register: gates the result with the reference-valid flag.
    logic signed [OW-1:0] out_speed_reg [4];
    logic                 out_clip_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int w = 0; w < 4; w++)
                out_speed_reg[w] <= refv_reg[TOT-2] ? speeds[w] : '0;
            out_clip_reg <= refv_reg[TOT-2] & (|clips);
        end
    end

    assign wheel.valid             = vld_reg[TOT-1];
    assign wheel.speed_front_left  = out_speed_reg[0];
    assign wheel.speed_front_right = out_speed_reg[1];
    assign wheel.speed_rear_right  = out_speed_reg[2];
    assign wheel.speed_rear_left   = out_speed_reg[3];
    assign wheel.clipped           = out_clip_reg;

endmodule

FILE: hw/rtl/mwk_checker.sv
// ============================================================================
// mwk_checker
// Port-level checks of the wheel speed kinematics unit, bound to the top.
// ============================================================================
module mwk_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [mwk_pkg::SPEED_W-1:0] spd_fl,
    input logic signed [mwk_pkg::SPEED_W-1:0] spd_fr,
    input logic signed [mwk_pkg::SPEED_W-1:0] spd_rr,
    input logic signed [mwk_pkg::SPEED_W-1:0] spd_rl,
    input logic                               clipped
);

    localparam logic [mwk_pkg::SPEED_W-1:0] SMAX = {1'b0, {(mwk_pkg::SPEED_W-1){1'b1}}};
    localparam logic [mwk_pkg::SPEED_W-1:0] SMIN = {1'b1, {(mwk_pkg::SPEED_W-1){1'b0}}};

    // A waiting result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // A waiting result beat keeps its front-left and rear-left speeds and its clipped flag.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(spd_fl) && $stable(spd_rl) && $stable(clipped))
        else $error("result payload changed while stalled");

    // The pipeline takes a command exactly when it can advance.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("command ready does not follow the output stall");

    // A clipped result has at least one wheel at a limit.
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            (spd_fl == SMAX) || (spd_fl == SMIN) || (spd_fr == SMAX) || (spd_fr == SMIN) ||
            (spd_rr == SMAX) || (spd_rr == SMIN) || (spd_rl == SMAX) || (spd_rl == SMIN))
        else $error("clipped flag without a saturated wheel speed");

endmodule

bind mecanum_wheel_speed_kinematics_unit mwk_checker u_mwk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (cmd.ready),
    .out_valid (wheel.valid),
    .out_ready (wheel.ready),
    .spd_fl    (wheel.speed_front_left),
    .spd_fr    (wheel.speed_front_right),
    .spd_rr    (wheel.speed_rear_right),
    .spd_rl    (wheel.speed_rear_left),
    .clipped   (wheel.clipped)
);
